FILE: sv/servo_easing_profile_defines.svh
// Assertion macros for the servo easing profile generator.
`ifndef SERVO_EASING_PROFILE_DEFINES_SVH
`define SERVO_EASING_PROFILE_DEFINES_SVH

// Check a condition in the same cycle; needs clk and rst in scope.
`define SEP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("servo easing profile: same-cycle check failed");

// Check a condition in the next cycle; needs clk and rst in scope.
`define SEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("servo easing profile: next-cycle check failed");

`endif

FILE: sv/sep_pkg.sv
// Types and constants shared by the servo easing profile generator.
package sep_pkg;

  localparam int DUR_W     = 14;
  localparam int ANGLE_W   = 8;
  localparam int FRAC_W    = 16;
  localparam int MCAND_W   = 20;
  localparam int ACC_W     = MCAND_W + FRAC_W;
  localparam int CFG_DATA_W = DUR_W;
  localparam int CNT_W     = 4;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_CURVE_MODE = 2'd0;
  localparam cfg_index_t CFG_DURATION   = 2'd1;
  localparam cfg_index_t CFG_TARGET     = 2'd2;

  localparam logic               RST_CURVE_MODE = 1'b0;
  localparam logic [DUR_W-1:0]   RST_DURATION   = 14'd1000;
  localparam logic [ANGLE_W-1:0] RST_TARGET     = 8'd90;

  localparam logic [DUR_W:0]     TICK_MS     = 15'd10;
  localparam logic [DUR_W-1:0]   ELAPSED_MAX = 14'd16383;
  localparam logic [MCAND_W-1:0] THREE_Q16   = 20'd196608;
  localparam logic [MCAND_W:0]   TEN_Q16     = 21'd655360;
  localparam logic [CNT_W-1:0]   LAST_STEP   = 4'd15;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_POLY,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_SQ,
    OP_CUBE,
    OP_EASE,
    OP_SCALE
  } mul_op_t;

endpackage

FILE: sv/sep_if.sv
// Handshake interfaces for the tick input and the angle output channels.
interface sep_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface sep_angle_if;
  import sep_pkg::*;

  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_deg;
  logic               last;

  modport source (output valid, output angle_deg, output last, input ready);
  modport sink (input valid, input angle_deg, input last, output ready);
endinterface

FILE: sv/servo_easing_profile.sv
// Eased servo angle generator: one word per 10 ms tick, zero or one angle word out.
//
// Each accepted tick either ends at once (idle, zero duration, move already
// over: no output word) or runs the fraction elapsed/duration through a
// restoring divider, one quotient bit per cycle, and then through one
// shared shift-add multiplier that takes one multiplier bit per cycle.
// Smoothstep needs three products; smootherstep needs four products plus
// a polynomial sum state. No new tick is taken until the word of the
// current one has gone into the output register. The finished word sits
// in that output register, and a new tick is taken while that word waits;
// a second finished word waits inside the block until the first is taken.
// Configuration writes are taken in any cycle and only meant while idle.
module servo_easing_profile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  sep_pkg::cfg_index_t           cfg_index,
  input  logic [sep_pkg::CFG_DATA_W-1:0] cfg_data,
  sep_tick_if.sink                      tick,
  sep_angle_if.source                   profile
);
  import sep_pkg::*;

  state_t               state;
  state_t               state_next;
  mul_op_t              op;

  logic                 curve_mode;
  logic [DUR_W-1:0]     duration;
  logic [ANGLE_W-1:0]   target;

  logic [DUR_W-1:0]     elapsed;
  logic                 moving;
  logic                 last_flag;

  logic [CNT_W-1:0]     cnt;
  logic [DUR_W-1:0]     rem;
  logic [FRAC_W-1:0]    quo;
  logic [FRAC_W-1:0]    x;
  logic [FRAC_W-1:0]    mplier;
  logic [MCAND_W-1:0]   mcand;
  logic [MCAND_W-1:0]   p;
  logic [ACC_W-1:0]     acc;
  logic [ANGLE_W-1:0]   ang;

  logic                 out_valid;
  logic [ANGLE_W-1:0]   out_angle;
  logic                 out_last;

  logic                 accept;
  logic                 run;
  logic [DUR_W-1:0]     el0;
  logic                 start;
  logic [DUR_W:0]       el_sum;
  logic [DUR_W-1:0]     el_sat;

  logic [DUR_W:0]       r2;
  logic                 ge;
  logic [DUR_W:0]       diff;
  logic [DUR_W-1:0]     rem_next;
  logic [FRAC_W-1:0]    x_new;

  logic [MCAND_W:0]     mul_sum;
  logic [ACC_W-1:0]     acc_next;
  logic [FRAC_W-1:0]    prod_hi;
  logic [34:0]          six_xx;
  logic [MCAND_W-1:0]   k;
  logic [MCAND_W:0]     poly_sum;
  logic                 load_out;

  // tick decode
  always_comb begin
    accept = tick.valid && (state == S_IDLE);
    run    = tick.restart || moving;
    el0    = tick.restart ? '0 : elapsed;
    start  = run && (el0 < duration);
    el_sum = {1'b0, el0} + TICK_MS;
    el_sat = el_sum[DUR_W] ? ELAPSED_MAX : el_sum[DUR_W-1:0];
  end

  // divider step
  always_comb begin
    r2       = {rem, 1'b0};
    ge       = r2 >= {1'b0, duration};
    diff     = r2 - {1'b0, duration};
    rem_next = ge ? diff[DUR_W-1:0] : r2[DUR_W-1:0];
    x_new    = {quo[FRAC_W-2:0], ge};
  end

  // multiplier step and polynomial terms
  always_comb begin
    mul_sum  = {1'b0, acc[ACC_W-1:FRAC_W]} + (mplier[0] ? {1'b0, mcand} : '0);
    acc_next = {mul_sum, acc[FRAC_W-1:1]};
    prod_hi  = acc_next[2*FRAC_W-1:FRAC_W];
    six_xx   = {1'b0, acc_next[2*FRAC_W-1:0], 2'b00}
             + {2'b00, acc_next[2*FRAC_W-1:0], 1'b0};
    k        = THREE_Q16 - {3'b000, x, 1'b0};
    poly_sum = {1'b0, p} + TEN_Q16 - {1'b0, x, 4'b0000} + {5'b00000, x};
    load_out = (state == S_DONE) && (!out_valid || profile.ready);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && start) state_next = S_DIV;
      end
      S_DIV: begin
        if (cnt == LAST_STEP) state_next = S_MUL;
      end
      S_MUL: begin
        if (cnt == LAST_STEP) begin
          case (op)
            OP_CUBE:  state_next = S_POLY;
            OP_SCALE: state_next = S_DONE;
            default:  state_next = S_MUL;
          endcase
        end
      end
      S_POLY: begin
        state_next = S_MUL;
      end
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    tick.ready        = (state == S_IDLE);
    profile.valid     = out_valid;
    profile.angle_deg = out_angle;
    profile.last      = out_last;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      moving     <= 1'b0;
      elapsed    <= '0;
      out_valid  <= 1'b0;
      curve_mode <= RST_CURVE_MODE;
      duration   <= RST_DURATION;
      target     <= RST_TARGET;
    end else begin
      state <= state_next;
      if (state == S_DIV || state == S_MUL) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (accept) begin
        if (start) begin
          elapsed <= el_sat;
          moving  <= el_sat < duration;
        end else if (run) begin
          elapsed <= el0;
          moving  <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (profile.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CURVE_MODE: curve_mode <= cfg_data[0];
          CFG_DURATION:   duration   <= cfg_data[DUR_W-1:0];
          CFG_TARGET:     target     <= cfg_data[ANGLE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && start) begin
          rem       <= el0;
          quo       <= '0;
          last_flag <= el_sat >= duration;
        end
      end
      S_DIV: begin
        rem <= rem_next;
        quo <= x_new;
        if (cnt == LAST_STEP) begin
          x      <= x_new;
          op     <= OP_SQ;
          mcand  <= {{(MCAND_W-FRAC_W){1'b0}}, x_new};
          mplier <= x_new;
          acc    <= '0;
        end
      end
      S_MUL: begin
        if (cnt == LAST_STEP) begin
          acc <= '0;
          case (op)
            OP_SQ: begin
              mplier <= prod_hi;
              if (curve_mode) begin
                op    <= OP_CUBE;
                mcand <= {{(MCAND_W-FRAC_W){1'b0}}, x};
                p     <= {1'b0, six_xx[34:FRAC_W]};
              end else begin
                op    <= OP_EASE;
                mcand <= k;
              end
            end
            OP_CUBE: begin
              mplier <= prod_hi;
            end
            OP_EASE: begin
              op     <= OP_SCALE;
              mplier <= prod_hi;
              mcand  <= {{(MCAND_W-ANGLE_W){1'b0}}, target};
            end
            OP_SCALE: begin
              ang <= acc_next[FRAC_W+ANGLE_W-1:FRAC_W];
            end
            default: begin
            end
          endcase
        end else begin
          acc    <= acc_next;
          mplier <= {1'b0, mplier[FRAC_W-1:1]};
        end
      end
      S_POLY: begin
        op    <= OP_EASE;
        mcand <= poly_sum[MCAND_W-1:0];
      end
      S_DONE: begin
        if (load_out) begin
          out_angle <= ang;
          out_last  <= last_flag;
        end
      end
      default: begin
      end
    endcase
  end

`include "servo_easing_profile_defines.svh"

  `SEP_ASSERT_NOW(a_rem_below_dur, state == S_DIV, rem < duration)
  `SEP_ASSERT_NOW(a_word_from_done, $rose(profile.valid), $past(state) == S_DONE)
  `SEP_ASSERT_NEXT(a_div_to_square, (state == S_DIV) && (cnt == LAST_STEP),
                   (state == S_MUL) && (op == OP_SQ) && (cnt == '0))

endmodule

FILE: tb/tb_servo_easing_profile.sv
// Testbench for servo_easing_profile: eased angle words checked against a tick-by-tick predictor.
`timescale 1ns / 100ps

import sep_pkg::*;

class ease_scoreboard;
  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic               last;
  } angle_word_t;

  bit                 curve_mode;
  bit [DUR_W-1:0]     duration;
  bit [ANGLE_W-1:0]   target;
  bit [DUR_W-1:0]     elapsed;
  bit                 moving;
  angle_word_t        expected_words[$];
  int unsigned        errors;

  function new();
    curve_mode = RST_CURVE_MODE;
    duration   = RST_DURATION;
    target     = RST_TARGET;
    elapsed    = '0;
    moving     = 1'b0;
    errors     = 0;
  endfunction

  function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CURVE_MODE: curve_mode = data[0];
      CFG_DURATION:   duration = data[DUR_W-1:0];
      CFG_TARGET:     target = data[ANGLE_W-1:0];
      default: ;
    endcase
  endfunction

  function bit [FRAC_W-1:0] ease_q16(bit [63:0] x);
    bit [63:0] x2, x3, k, p;
    x2 = (x * x) >> FRAC_W;
    if (!curve_mode) begin
      k = 64'(THREE_Q16) - (x << 1);
      return FRAC_W'((x2 * k) >> FRAC_W);
    end
    x3 = (x2 * x) >> FRAC_W;
    p = (64'd6 * x * x + (64'd10 << 32) - ((64'd15 * x) << FRAC_W)) >> FRAC_W;
    return FRAC_W'((x3 * p) >> FRAC_W);
  endfunction

  // Returns 1 when the tick is a restart or comes while a move is running.
  function bit note_tick(bit restart);
    bit [63:0]    x;
    bit [63:0]    scaled;
    bit [DUR_W:0] nxt;
    angle_word_t  w;
    bit           engaged;
    engaged = restart | moving;
    if (restart) begin
      elapsed = '0;
      moving = 1'b1;
    end
    if (!moving) return engaged;
    if (elapsed >= duration) begin
      moving = 1'b0;
      return engaged;
    end
    x = (64'(elapsed) << FRAC_W) / 64'(duration);
    scaled = (64'(target) * 64'(ease_q16(x))) >> FRAC_W;
    nxt = {1'b0, elapsed} + TICK_MS;
    if (nxt > {1'b0, ELAPSED_MAX}) nxt = {1'b0, ELAPSED_MAX};
    elapsed = nxt[DUR_W-1:0];
    w.angle_deg = scaled[ANGLE_W-1:0];
    w.last = (elapsed >= duration);
    if (w.last) moving = 1'b0;
    expected_words.push_back(w);
    return engaged;
  endfunction

  function void check_word(logic [ANGLE_W-1:0] angle_deg, logic last);
    angle_word_t w;
    if (expected_words.size() == 0) begin
      $error("angle word with none expected: angle_deg %0d, last %0d", angle_deg, last);
      errors++;
      return;
    end
    w = expected_words.pop_front();
    if (angle_deg !== w.angle_deg) begin
      $error("angle_deg: expected %0d, actual %0d", w.angle_deg, angle_deg);
      errors++;
    end
    if (last !== w.last) begin
      $error("last: expected %0d, actual %0d", w.last, last);
      errors++;
    end
  endfunction
endclass

module tb_servo_easing_profile;
  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sep_tick_if  tick_ch();
  sep_angle_if angle_ch();

  ease_scoreboard sb = new();

  bit send_quiet;
  bit ready_quiet;
  int stall_left;
  int engaged_ticks;

  servo_easing_profile i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .profile   (angle_ch)
  );

  always #1 clk = ~clk;

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      angle_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!ready_quiet && $urandom_range(0, 99) < 20) begin
      angle_ch.ready <= 1'b0;
      stall_left <= pick_len() - 1;
    end else begin
      angle_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && angle_ch.valid === 1'b1 && angle_ch.ready === 1'b1)
      sb.check_word(angle_ch.angle_deg, angle_ch.last);
  end

  task automatic send_tick(bit r);
    int gap;
    gap = (send_quiet || $urandom_range(0, 99) < 55) ? 0 : pick_len();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.restart <= r;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    if (sb.note_tick(r)) engaged_ticks++;
  endtask

  task automatic finish_phase();
    tick_ch.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic set_config(bit mode, logic [DUR_W-1:0] dur, logic [ANGLE_W-1:0] tgt);
    write_reg(CFG_CURVE_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_DURATION, CFG_DATA_W'(dur));
    write_reg(CFG_TARGET, CFG_DATA_W'(tgt));
    cfg_we <= 1'b0;
  endtask

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int               n, u;
    bit               well;
    logic [DUR_W-1:0] dur;
    logic [ANGLE_W-1:0] tgt;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_CURVE_MODE;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.restart = 1'b0;
    angle_ch.ready = 1'b0;
    stall_left = 0;
    send_quiet = 1'b0;
    ready_quiet = 1'b0;
    engaged_ticks = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: idle tick, a move, then a restart in mid move
    send_tick(1'b0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);
    finish_phase();

    set_config(1'b1, 14'd30, 8'd180);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    finish_phase();

    set_config(1'b0, 14'd0, 8'd255);
    send_tick(1'b1);
    send_tick(1'b0);
    finish_phase();

    set_config(1'b0, 14'd1, 8'd0);
    send_tick(1'b1);
    finish_phase();

    // shorten the duration under a running move
    set_config(1'b1, 14'd100, 8'd255);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    finish_phase();
    set_config(1'b1, 14'd40, 8'd255);
    repeat (2) send_tick(1'b0);
    finish_phase();

    set_config(1'b0, 14'd10000, 8'd180);
    send_tick(1'b1);
    send_tick(1'b0);
    finish_phase();

    engaged_ticks = 0;
    while (engaged_ticks < 850) begin
      u = $urandom_range(0, 99);
      if (u < 5) dur = '0;
      else if (u < 12) dur = DUR_W'($urandom_range(1, 9));
      else if (u < 16) dur = DUR_W'($urandom_range(10000, 16383));
      else if (u < 18) dur = ELAPSED_MAX;
      else dur = DUR_W'($urandom_range(10, 400));
      u = $urandom_range(0, 99);
      if (u < 10) tgt = '0;
      else if (u < 20) tgt = 8'd180;
      else if (u < 30) tgt = 8'd255;
      else tgt = ANGLE_W'($urandom_range(0, 255));
      set_config(1'($urandom_range(0, 1)), dur, tgt);
      send_quiet = ($urandom_range(0, 4) == 0);
      ready_quiet = ($urandom_range(0, 4) == 0);
      well = ($urandom_range(0, 99) < 85);
      n = $urandom_range(4, 45);
      for (int i = 0; i < n; i++) begin
        if (well) send_tick((i == 0) || ($urandom_range(0, 99) < 3));
        else send_tick($urandom_range(0, 99) < 30);
      end
      finish_phase();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
